// File: hdl/cscv_pkg.sv
// cscv_pkg: constants, calendar tables, helper functions and the result type
// shared by the calendar/seconds converter modules
// no dependencies
package cscv_pkg;

  localparam int unsigned YEAR_BASE      = 2000;
  localparam int unsigned NUM_YEARS      = 100;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 60 * 60;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned MONTHS         = 12;

  // reciprocals for the constant divides, exact over the operand ranges seen
  // days: (secs >> 7) / 675, hours: (rem >> 4) / 225, minutes: (rem >> 2) / 15
  localparam int unsigned DAY_RECIP      = 50903317;  // ceil(2^35 / 675)
  localparam int unsigned HOUR_RECIP     = 9321;      // ceil(2^21 / 225)
  localparam int unsigned MIN_RECIP      = 1093;      // ceil(2^14 / 15)

  // configuration port
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned DATA_W         = 32;
  localparam logic        REG_BASE_WDAY  = 1'b0;  // word index of base_jan1_weekday
  localparam logic [2:0]  BASE_WDAY_RST  = 3'd6;

  typedef logic [8:0] doy_t;

  localparam doy_t MONTH_START [2][13] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
      9'd334, 9'd365},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274, 9'd305,
      9'd335, 9'd366}
  };

  // gregorian leap flags for each year from the base year on, worked out at elaboration
  function automatic logic [NUM_YEARS-1:0] leap_mask_f();
    logic [NUM_YEARS-1:0] m;
    int unsigned y;
    m = '0;
    for (int i = 0; i < NUM_YEARS; i++) begin
      y = YEAR_BASE + i;
      m[i] = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    end
    return m;
  endfunction

  localparam logic [NUM_YEARS-1:0] LEAP_MASK = leap_mask_f();

  function automatic logic is_leap(input logic [6:0] yoff);
    logic r;
    r = 1'b0;
    if (yoff < 7'(NUM_YEARS)) begin
      r = LEAP_MASK[yoff];
    end
    return r;
  endfunction

  function automatic logic [8:0] year_len(input logic [6:0] yoff);
    return 9'(DAYS_PER_YEAR) + 9'(is_leap(yoff));
  endfunction

  function automatic doy_t month_start(input logic leap, input logic [3:0] idx);
    doy_t r;
    r = '0;
    if (idx <= 4'(MONTHS)) begin
      r = MONTH_START[leap][idx];
    end
    return r;
  endfunction

  // february is held to 28 days in every year
  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] r;
    case (mo) inside
      4'd2:                     r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

  // modulo 7 by summing octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] r;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      r = 3'(s2 - 4'd7);
    end else begin
      r = 3'(s2);
    end
    return r;
  endfunction

  typedef struct packed {
    logic [31:0] seconds;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  date;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        invalid;
  } cscv_result_t;

endpackage

// File: hdl/cscv_alu.sv
// cscv_alu: shared 32-bit adder/subtractor with carry out, used by the sequencer
// for the day and second sums, the remainder subtracts and the year and month steps
// no dependencies
module cscv_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic [31:0] res,
  output logic        cout
);

  logic [32:0] total;

  // on subtract the carry out means a >= b
  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + 33'(sub);
  assign res   = total[31:0];
  assign cout  = total[32];

endmodule

// File: hdl/cscv_core.sv
// cscv_core: sequencer and working registers of the converter
// depends on cscv_pkg and cscv_alu
module cscv_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  action,
  input  logic [6:0]            year_in,
  input  logic [3:0]            month_in,
  input  logic [4:0]            date_in,
  input  logic [4:0]            hour_in,
  input  logic [5:0]            minute_in,
  input  logic [5:0]            second_in,
  input  logic [31:0]           seconds_in,
  input  logic [2:0]            base_wday,
  output logic                  busy,
  output logic                  done,
  output cscv_pkg::cscv_result_t result
);
  import cscv_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_YADD  = 15'b000000000000010,
    S_MADD  = 15'b000000000000100,
    S_MUL   = 15'b000000000001000,
    S_ADDT  = 15'b000000000010000,
    S_DIVD  = 15'b000000000100000,
    S_REMD  = 15'b000000001000000,
    S_DIVH  = 15'b000000010000000,
    S_REMH  = 15'b000000100000000,
    S_DIVM  = 15'b000001000000000,
    S_REMM  = 15'b000010000000000,
    S_YSUB  = 15'b000100000000000,
    S_MCMP  = 15'b001000000000000,
    S_MDATE = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t      state;
  logic        act;
  logic        inv;
  logic [31:0] acc;
  logic [15:0] days;
  logic [15:0] wd_days;
  logic [6:0]  yr;
  logic [6:0]  y_lim;
  logic [3:0]  mon;
  logic [4:0]  dt;
  logic [4:0]  hr;
  logic [5:0]  mi;
  logic [5:0]  sc;

  logic        accept;
  logic        fields_ok;
  logic        lp;
  logic [8:0]  ylen;
  logic [8:0]  doy_off;
  logic [16:0] tod;
  logic [32:0] day_secs;
  logic [50:0] day_prod;
  logic [25:0] hr_prod;
  logic [19:0] min_prod;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_res;
  logic        alu_cout;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign fields_ok = (year_in < 7'(NUM_YEARS)) && (month_in >= 4'd1) &&
                     (month_in <= 4'(MONTHS)) && (date_in >= 5'd1) &&
                     (date_in <= month_len(month_in)) && (hour_in <= 5'd23) &&
                     (minute_in <= 6'd59) && (second_in <= 6'd59);

  assign lp       = is_leap(yr);
  assign ylen     = year_len(yr);
  assign doy_off  = month_start(lp, mon - 4'd1) + 9'(dt) - 9'd1;
  assign tod      = 17'(hr) * 17'(SECS_PER_HOUR) + 17'(mi) * 17'(SECS_PER_MIN) + 17'(sc);
  assign day_secs = {17'd0, days} * 33'(SECS_PER_DAY);

  // quotients by reciprocal multiplication, the remainder follows on the shared adder
  assign day_prod = 51'(acc[31:7]) * 51'(DAY_RECIP);
  assign hr_prod  = 26'(acc[16:4]) * 26'(HOUR_RECIP);
  assign min_prod = 20'(acc[11:2]) * 20'(MIN_RECIP);

  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_YADD: begin
        alu_a = 32'(days);
        alu_b = 32'(ylen);
      end
      S_MADD: begin
        alu_a = 32'(days);
        alu_b = 32'(doy_off);
      end
      S_ADDT: begin
        alu_b = 32'(tod);
      end
      S_REMD: begin
        alu_b   = day_secs[31:0];
        alu_sub = 1'b1;
      end
      S_REMH: begin
        alu_b   = 32'(hr) * 32'(SECS_PER_HOUR);
        alu_sub = 1'b1;
      end
      S_REMM: begin
        alu_b   = 32'(mi) * 32'(SECS_PER_MIN);
        alu_sub = 1'b1;
      end
      S_YSUB: begin
        alu_a   = 32'(days);
        alu_b   = 32'(ylen);
        alu_sub = 1'b1;
      end
      S_MCMP: begin
        alu_a   = 32'(days);
        alu_b   = 32'(month_start(lp, mon));
        alu_sub = 1'b1;
      end
      S_MDATE: begin
        alu_a   = 32'(days);
        alu_b   = 32'(month_start(lp, mon - 4'd1));
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  cscv_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .cout (alu_cout)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (action) begin
              state <= S_DIVD;
            end else if (fields_ok) begin
              state <= S_YADD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_YADD: begin
          if (yr == y_lim) begin
            state <= S_MADD;
          end
        end
        S_MADD:  state <= S_MUL;
        S_MUL:   state <= S_ADDT;
        S_ADDT:  state <= S_FIN;
        S_DIVD:  state <= S_REMD;
        S_REMD:  state <= S_DIVH;
        S_DIVH:  state <= S_REMH;
        S_REMH:  state <= S_DIVM;
        S_DIVM:  state <= S_REMM;
        S_REMM:  state <= S_YSUB;
        S_YSUB: begin
          if (yr == 7'(NUM_YEARS)) begin
            state <= S_FIN;
          end else if (!alu_cout) begin
            state <= S_MCMP;
          end
        end
        S_MCMP: begin
          if (!(mon < 4'(MONTHS) && alu_cout)) begin
            state <= S_MDATE;
          end
        end
        S_MDATE: state <= S_FIN;
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          act   <= action;
          inv   <= !action && !fields_ok;
          acc   <= seconds_in;
          days  <= '0;
          yr    <= '0;
          y_lim <= year_in;
          mon   <= month_in;
          dt    <= date_in;
          hr    <= hour_in;
          mi    <= minute_in;
          sc    <= second_in;
        end
      end
      S_YADD: begin
        if (yr != y_lim) begin
          days <= alu_res[15:0];
          yr   <= yr + 7'd1;
        end
      end
      S_MADD: begin
        days    <= alu_res[15:0];
        wd_days <= alu_res[15:0];
      end
      S_MUL:  acc <= day_secs[31:0];
      S_ADDT: acc <= alu_res;
      S_DIVD: begin
        days    <= day_prod[50:35];
        wd_days <= day_prod[50:35];
      end
      S_REMD: acc <= alu_res;
      S_DIVH: hr  <= hr_prod[25:21];
      S_REMH: acc <= alu_res;
      S_DIVM: mi  <= min_prod[19:14];
      S_REMM: begin
        sc <= alu_res[5:0];
        yr <= '0;
      end
      S_YSUB: begin
        if (yr == 7'(NUM_YEARS)) begin
          inv <= 1'b1;
        end else if (alu_cout) begin
          days <= alu_res[15:0];
          yr   <= yr + 7'd1;
        end else begin
          mon <= 4'd1;
        end
      end
      S_MCMP: begin
        if (mon < 4'(MONTHS) && alu_cout) begin
          mon <= mon + 4'd1;
        end
      end
      S_MDATE: dt <= alu_res[4:0] + 5'd1;
      S_FIN: begin
        if (inv) begin
          result <= '{invalid: 1'b1, default: '0};
        end else begin
          result.seconds <= act ? 32'd0 : acc;
          result.year    <= yr;
          result.month   <= mon;
          result.date    <= dt;
          result.hour    <= hr;
          result.minute  <= mi;
          result.second  <= sc;
          result.weekday <= mod7(wd_days + 16'(base_wday));
          result.invalid <= 1'b0;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

// File: hdl/calendar_seconds_converter.sv
// calendar_seconds_converter: top level with the configuration register port
// depends on cscv_pkg and cscv_core
//
// One conversion per transaction: start is taken when busy is low, and the result
// is registered onto the output ports as done goes high for a single cycle; the
// receiver must take it then, as there is no way to hold it off. Action 0 (fields
// to seconds) walks the years on the shared adder, then adds the month offset,
// scales the days to seconds and adds the time of day; fields that fail the checks
// go straight to an invalid result. Action 1 (seconds to fields) splits off days,
// hours and minutes by reciprocal multiplication, each followed by a remainder
// subtract on the shared adder, then the same shared unit subtracts year lengths in
// turn, compares the day count with the month starts and subtracts the start of the
// month found. A count beyond year 99 gives an invalid result.
// base_jan1_weekday lives at byte address 0 and resets to 6.
module calendar_seconds_converter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [6:0]                  year_in,
  input  logic [3:0]                  month_in,
  input  logic [4:0]                  date_in,
  input  logic [4:0]                  hour_in,
  input  logic [5:0]                  minute_in,
  input  logic [5:0]                  second_in,
  input  logic [31:0]                 seconds_in,
  output logic                        done,
  output logic [31:0]                 seconds_out,
  output logic [6:0]                  year_out,
  output logic [3:0]                  month_out,
  output logic [4:0]                  date_out,
  output logic [4:0]                  hour_out,
  output logic [5:0]                  minute_out,
  output logic [5:0]                  second_out,
  output logic [2:0]                  weekday_out,
  output logic                        invalid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cscv_pkg::ADDR_W-1:0] paddr,
  input  logic [cscv_pkg::DATA_W-1:0] pwdata,
  output logic [cscv_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import cscv_pkg::*;

  logic [2:0]   base_wday;
  logic         reg_sel;
  cscv_result_t result;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_BASE_WDAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_wday <= BASE_WDAY_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      base_wday <= pwdata[2:0];
    end
  end

  assign prdata = reg_sel ? DATA_W'(base_wday) : '0;

  cscv_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .year_in    (year_in),
    .month_in   (month_in),
    .date_in    (date_in),
    .hour_in    (hour_in),
    .minute_in  (minute_in),
    .second_in  (second_in),
    .seconds_in (seconds_in),
    .base_wday  (base_wday),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  assign seconds_out = result.seconds;
  assign year_out    = result.year;
  assign month_out   = result.month;
  assign date_out    = result.date;
  assign hour_out    = result.hour;
  assign minute_out  = result.minute;
  assign second_out  = result.second;
  assign weekday_out = result.weekday;
  assign invalid     = result.invalid;

endmodule
